// File: rtl/sd_spi_mode_card_init_top_macros.svh
// Assertion macros shared by the SD card SPI-mode init sequencer RTL.
`ifndef SD_SPI_MODE_CARD_INIT_TOP_MACROS_SVH
`define SD_SPI_MODE_CARD_INIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SDI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SDI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sdi_pkg.sv
// Types, constants and the command frame function of the SD card init sequencer.
`default_nettype none
package sdi_pkg;

  localparam int unsigned CNT_W = 16;

  // Request kinds.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Command indexes.
  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  localparam logic [7:0]  CMD_START  = 8'h40;
  localparam logic [7:0]  CRC_CMD0   = 8'h95;
  localparam logic [7:0]  CRC_CMD8   = 8'h87;
  localparam logic [7:0]  CRC_DUMMY  = 8'h01;
  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
  localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
  localparam logic [7:0]  R1_IDLE    = 8'h01;
  localparam logic [7:0]  R1_READY   = 8'h00;
  localparam logic [7:0]  ECHO_CHECK = 8'hAA;
  localparam logic [3:0]  FRAME_LEN  = 4'd6;
  localparam logic [3:0]  TAIL_LEN   = 4'd4;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_IDLE   = 3'd1;
  localparam logic [2:0] ST_ECHO_BAD  = 3'd2;
  localparam logic [2:0] ST_RETRY_OUT = 3'd3;
  localparam logic [2:0] ST_CMD58_BAD = 3'd4;

  // Card types.
  localparam logic [1:0] CT_UNKNOWN = 2'd0;
  localparam logic [1:0] CT_SDSC    = 2'd1;
  localparam logic [1:0] CT_SDHC    = 2'd2;

  // Register word indexes on the configuration port.
  localparam logic REG_RETRY_LIMIT = 1'b0;
  localparam logic REG_WAIT_LIMIT  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_low;
    logic       done_res;
    logic [2:0] status;
    logic [1:0] card_type;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] retry_limit;
    logic [CNT_W-1:0] wait_limit;
  } cfg_t;

  // Byte idx of the six byte frame for command cmd.
  function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic v2,
                                            input logic [3:0] idx);
    logic [31:0] arg;
    logic [7:0]  b;
    arg = '0;
    if (cmd == CMD8) arg = ARG_CMD8;
    if (cmd == CMD41 && v2) arg = ARG_HCS;
    case (idx)
      4'd0: b = CMD_START | {2'b00, cmd};
      4'd1: b = arg[31:24];
      4'd2: b = arg[23:16];
      4'd3: b = arg[15:8];
      4'd4: b = arg[7:0];
      default: begin
        if (cmd == CMD0) b = CRC_CMD0;
        else if (cmd == CMD8) b = CRC_CMD8;
        else b = CRC_DUMMY;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sd_spi_mode_card_init_top.sv
// SD card SPI-mode init sequencer (an input beat register, step logic, a result register).
// Use: send a beat with in_tuser = 0 to start the sequence; the result gives the first byte
// to exchange over SPI. After each exchange send a beat with in_tuser = 1 and the byte the
// card returned in in_tdata; the result gives the next byte and the chip-select level.
// Exactly one result beat comes back for every input beat, in order.
// out_tuser is tx_valid; out_tlast marks the beat that ends the sequence and then
// out_tdata carries the status and card type.
// A beat accepted into the input register passes the step logic and is loaded into the result
// register, raising out_tvalid, once the output is free.
// Throughput: one beat per cycle while out_tready is high; step logic is a single pass
// between two registers. In a real link each beat stands for one SPI byte exchange.
// When the receiver holds out_tready low the result stays put, one more beat waits in the
// input register, and in_tready then drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the sequencer to idle and
// loads the limits with 1000 retries and 100 ready-wait bytes. The user must write the limits through
// the cfg_ port only while no beat is in flight; the block itself does not enforce this.
`default_nettype none
`include "sd_spi_mode_card_init_top_macros.svh"
module sd_spi_mode_card_init_top #(
  parameter int unsigned TRAIN_BYTES         = 10,
  parameter int unsigned RESPONSE_POLL_LIMIT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] tx_byte, [8] cs_low, [11:9] status,
                                       // [13:12] card_type, [15:14] zero
  output logic             out_tuser,  // [0] tx_valid
  output logic             out_tlast,  // done_res
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  sdi_pkg::cfg_t  cfg;
  sdi_pkg::item_t in_r;
  sdi_pkg::res_t  res;
  sdi_pkg::res_t  out_r;
  logic           in_vld_r;
  logic           out_vld_r;
  logic           advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r.req_type <= in_tuser;
      in_r.rx_byte  <= in_tdata;
    end
  end

  sdi_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sdi_seq #(
    .TRAIN_BYTES         (TRAIN_BYTES),
    .RESPONSE_POLL_LIMIT (RESPONSE_POLL_LIMIT)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.tx_valid;
  assign out_tlast  = out_r.done_res;
  assign out_tdata  = {2'b00, out_r.card_type, out_r.status, out_r.cs_low, out_r.tx_byte};

  `SDI_ASSERT_NXT(a_step_fills_out, advance, out_vld_r, "step result was not registered")
  `SDI_ASSERT_NXT(a_in_beat_kept, in_vld_r && !advance, in_vld_r, "waiting input beat was lost")
  `SDI_ASSERT_IMP(a_done_no_tx, out_tvalid && out_tlast, !out_tuser,
                  "final beat also asks for a byte exchange")
  `SDI_ASSERT_IMP(a_cs_needs_tx, out_tvalid && !out_tuser, !out_tdata[8],
                  "card selected without a byte exchange")

endmodule
`default_nettype wire

// File: rtl/sdi_cfg_regs.sv
// APB-style register file holding the retry and ready-wait limits.
`default_nettype none
module sdi_cfg_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output sdi_pkg::cfg_t           cfg
);

  logic [sdi_pkg::CNT_W-1:0] retry_r;
  logic [sdi_pkg::CNT_W-1:0] wait_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Registers are word aligned; the low address bits are not decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r <= 16'd1000;
      wait_r  <= 16'd100;
    end else if (wr_en) begin
      if (paddr[2] == sdi_pkg::REG_RETRY_LIMIT) retry_r <= pwdata[sdi_pkg::CNT_W-1:0];
      else wait_r <= pwdata[sdi_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == sdi_pkg::REG_RETRY_LIMIT) prdata = {16'd0, retry_r};
    else prdata = {16'd0, wait_r};
  end

  assign cfg.retry_limit = retry_r;
  assign cfg.wait_limit  = wait_r;

endmodule
`default_nettype wire

// File: rtl/sdi_seq.sv
// Sequencer state and the single-pass step logic that maps one received byte to the next.
`default_nettype none
module sdi_seq #(
  parameter int unsigned TRAIN_BYTES         = 10,
  parameter int unsigned RESPONSE_POLL_LIMIT = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   step_en,
  input  wire sdi_pkg::item_t item,
  input  wire sdi_pkg::cfg_t  cfg,
  output sdi_pkg::res_t  res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TRAIN = 3'd1;
  localparam logic [2:0] PH_WAIT  = 3'd2;
  localparam logic [2:0] PH_FRAME = 3'd3;
  localparam logic [2:0] PH_POLL  = 3'd4;
  localparam logic [2:0] PH_TAIL  = 3'd5;

  localparam logic [sdi_pkg::CNT_W-1:0] TRAIN_N = sdi_pkg::CNT_W'(TRAIN_BYTES);
  localparam logic [sdi_pkg::CNT_W-1:0] POLL_N  = sdi_pkg::CNT_W'(RESPONSE_POLL_LIMIT);

  logic [2:0]                phase_r, phase_nxt;
  logic [3:0]                idx_r, idx_nxt;
  logic [sdi_pkg::CNT_W-1:0] wait_r, wait_nxt;
  logic [sdi_pkg::CNT_W-1:0] retry_r, retry_nxt;
  logic [5:0]                cmd_r, cmd_nxt;
  logic [7:0]                echo_r, echo_nxt;
  logic                      v2_r, v2_nxt;

  logic [sdi_pkg::CNT_W-1:0] wait_inc;
  logic [sdi_pkg::CNT_W-1:0] retry_inc;
  logic [3:0]                idx_inc;
  logic                      r1_seen;
  logic                      bc_en;
  logic [5:0]                bc_cmd;
  logic                      fin_en;
  logic [2:0]                fin_st;
  logic [1:0]                fin_ty;
  logic                      tail_en;
  sdi_pkg::res_t             busy_res;

  assign wait_inc  = wait_r + 1'b1;
  assign retry_inc = retry_r + 1'b1;
  assign idx_inc   = idx_r + 1'b1;
  assign busy_res  = '{tx_valid: 1'b1, tx_byte: sdi_pkg::IDLE_BYTE, cs_low: 1'b1,
                       done_res: 1'b0, status: sdi_pkg::ST_OK,
                       card_type: sdi_pkg::CT_UNKNOWN};

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    wait_nxt  = wait_r;
    retry_nxt = retry_r;
    cmd_nxt   = cmd_r;
    echo_nxt  = echo_r;
    v2_nxt    = v2_r;
    bc_en     = 1'b0;
    bc_cmd    = sdi_pkg::CMD0;
    fin_en    = 1'b0;
    fin_st    = sdi_pkg::ST_OK;
    fin_ty    = sdi_pkg::CT_UNKNOWN;
    tail_en   = 1'b0;
    res       = busy_res;
    r1_seen   = !item.rx_byte[7] || (wait_r >= POLL_N);

    if (item.req_type == sdi_pkg::REQ_START) begin
      phase_nxt  = PH_TRAIN;
      wait_nxt   = 16'd1;
      res.cs_low = 1'b0;
    end else begin
      case (phase_r)
        PH_TRAIN: begin
          if (wait_r < TRAIN_N) begin
            wait_nxt   = wait_inc;
            res.cs_low = 1'b0;
          end else begin
            bc_en  = 1'b1;
            bc_cmd = sdi_pkg::CMD0;
          end
        end
        PH_WAIT: begin
          wait_nxt = wait_inc;
          // A card still busy after the wait limit gets the frame anyway.
          if (item.rx_byte == sdi_pkg::IDLE_BYTE || wait_inc == cfg.wait_limit) begin
            phase_nxt   = PH_FRAME;
            idx_nxt     = 4'd1;
            res.tx_byte = sdi_pkg::frame_byte(cmd_r, v2_r, 4'd0);
          end
        end
        PH_FRAME: begin
          if (idx_r < sdi_pkg::FRAME_LEN) begin
            res.tx_byte = sdi_pkg::frame_byte(cmd_r, v2_r, idx_r);
            idx_nxt     = idx_inc;
          end else begin
            phase_nxt = PH_POLL;
            wait_nxt  = 16'd1;
          end
        end
        PH_POLL: begin
          if (r1_seen) begin
            case (cmd_r)
              sdi_pkg::CMD0: begin
                if (item.rx_byte != sdi_pkg::R1_IDLE) begin
                  fin_en = 1'b1;
                  fin_st = sdi_pkg::ST_NO_IDLE;
                end else begin
                  bc_en  = 1'b1;
                  bc_cmd = sdi_pkg::CMD8;
                end
              end
              sdi_pkg::CMD8: begin
                if (item.rx_byte == sdi_pkg::R1_IDLE) begin
                  v2_nxt  = 1'b1;
                  tail_en = 1'b1;
                end else begin
                  v2_nxt    = 1'b0;
                  retry_nxt = '0;
                  bc_en     = 1'b1;
                  bc_cmd    = sdi_pkg::CMD55;
                end
              end
              sdi_pkg::CMD55: begin
                bc_en  = 1'b1;
                bc_cmd = sdi_pkg::CMD41;
              end
              sdi_pkg::CMD41: begin
                retry_nxt = retry_inc;
                // Running out of attempts fails even on a ready answer.
                if (retry_inc == cfg.retry_limit) begin
                  fin_en = 1'b1;
                  fin_st = sdi_pkg::ST_RETRY_OUT;
                end else if (item.rx_byte != sdi_pkg::R1_READY) begin
                  bc_en  = 1'b1;
                  bc_cmd = sdi_pkg::CMD55;
                end else if (v2_r) begin
                  bc_en  = 1'b1;
                  bc_cmd = sdi_pkg::CMD58;
                end else begin
                  fin_en = 1'b1;
                  fin_ty = sdi_pkg::CT_SDSC;
                end
              end
              default: begin
                if (item.rx_byte != sdi_pkg::R1_READY) begin
                  fin_en = 1'b1;
                  fin_st = sdi_pkg::ST_CMD58_BAD;
                end else begin
                  tail_en = 1'b1;
                end
              end
            endcase
          end else begin
            wait_nxt = wait_inc;
          end
        end
        PH_TAIL: begin
          // CMD8 keeps the voltage byte; CMD58 keeps the first OCR byte.
          if (cmd_r == sdi_pkg::CMD8) begin
            if (idx_r == 4'd2) echo_nxt = item.rx_byte;
          end else if (idx_r == 4'd0) begin
            echo_nxt = item.rx_byte;
          end
          idx_nxt = idx_inc;
          if (idx_inc < sdi_pkg::TAIL_LEN) begin
            res = busy_res;
          end else if (cmd_r == sdi_pkg::CMD8) begin
            if (echo_nxt == sdi_pkg::R1_IDLE && item.rx_byte == sdi_pkg::ECHO_CHECK) begin
              retry_nxt = '0;
              bc_en     = 1'b1;
              bc_cmd    = sdi_pkg::CMD55;
            end else begin
              fin_en = 1'b1;
              fin_st = sdi_pkg::ST_ECHO_BAD;
            end
          end else begin
            fin_en = 1'b1;
            fin_ty = echo_nxt[6] ? sdi_pkg::CT_SDHC : sdi_pkg::CT_SDSC;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          res       = '0;
        end
      endcase
    end

    if (tail_en) begin
      phase_nxt = PH_TAIL;
      idx_nxt   = 4'd0;
    end
    if (bc_en) begin
      cmd_nxt   = bc_cmd;
      phase_nxt = PH_WAIT;
      wait_nxt  = '0;
      res       = busy_res;
    end
    if (fin_en) begin
      phase_nxt     = PH_IDLE;
      res           = '0;
      res.done_res  = 1'b1;
      res.status    = fin_st;
      res.card_type = fin_ty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      wait_r  <= '0;
      retry_r <= '0;
      cmd_r   <= sdi_pkg::CMD0;
      echo_r  <= '0;
      v2_r    <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      wait_r  <= wait_nxt;
      retry_r <= retry_nxt;
      cmd_r   <= cmd_nxt;
      echo_r  <= echo_nxt;
      v2_r    <= v2_nxt;
    end
  end

endmodule
`default_nettype wire
